### sv/sbot_pkg.sv
// Package for the sphere/oriented-box overlap test.
// Widths, payload types, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package sbot_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int ROT_FRAC_BITS = 14;
  localparam int ROT_BITS      = 16;
  localparam int EXT_BITS      = 21;

  localparam int HALF_EXT_WIDTH = 3 * EXT_BITS;
  localparam int ROT_ROW_WIDTH  = 3 * ROT_BITS;
  localparam int CFG_DATA_WIDTH = HALF_EXT_WIDTH;
  localparam int CFG_ADDR_WIDTH = 3;

  // Derived datapath widths
  localparam int DIFF_W  = COORD_WIDTH + 1;         // sphere minus centre
  localparam int PROD_W  = DIFF_W + ROT_BITS;       // one matrix term
  localparam int SUM_W   = PROD_W + 2;              // three terms
  localparam int LOCAL_W = SUM_W - ROT_FRAC_BITS;   // rounded local coordinate
  localparam int DIST_W  = LOCAL_W + 1;             // local minus half extent
  localparam int SQ_W    = 2 * COORD_WIDTH;
  localparam int TOTAL_W = SQ_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] radius_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [ROT_BITS-1:0]    rot_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [LOCAL_W-1:0]     local_t;
  typedef logic signed [DIST_W-1:0]      dist_t;
  typedef logic        [EXT_BITS-1:0]    ext_t;
  typedef logic        [SQ_W-1:0]        sq_t;
  typedef logic        [TOTAL_W-1:0]     total_t;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_BOX_CENTER_X  = 3'd0,
    CFG_BOX_CENTER_Y  = 3'd1,
    CFG_BOX_CENTER_Z  = 3'd2,
    CFG_HALF_EXTENTS  = 3'd3,
    CFG_ROT_ROW_0     = 3'd4,
    CFG_ROT_ROW_1     = 3'd5,
    CFG_ROT_ROW_2     = 3'd6,
    CFG_COLLISION_EN  = 3'd7
  } cfg_addr_t;

  localparam rot_t ROT_ONE = rot_t'(1 << ROT_FRAC_BITS);
  localparam rot_t ROT_ZERO = '0;
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_0_RESET = {ROT_ZERO, ROT_ZERO, ROT_ONE};
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_1_RESET = {ROT_ZERO, ROT_ONE, ROT_ZERO};
  localparam logic [ROT_ROW_WIDTH-1:0] ROT_ROW_2_RESET = {ROT_ONE, ROT_ZERO, ROT_ZERO};

  // Round to nearest, ties up: add half an LSB before the arithmetic shift
  localparam sum_t ROUND_HALF = sum_t'(1 << (ROT_FRAC_BITS - 1));

endpackage

### sv/sbot_if.sv
// Handshake channels for the sphere/oriented-box overlap test.
// Depends on sbot_pkg for the payload types.
`timescale 1ns / 1ps

interface sbot_query_if;
  logic             valid;
  logic             ready;
  sbot_pkg::coord_t  sphere_x;
  sbot_pkg::coord_t  sphere_y;
  sbot_pkg::coord_t  sphere_z;
  sbot_pkg::radius_t sphere_radius;

  modport source (output valid, sphere_x, sphere_y, sphere_z, sphere_radius, input ready);
  modport sink   (input valid, sphere_x, sphere_y, sphere_z, sphere_radius, output ready);
endinterface

interface sbot_result_if;
  logic valid;
  logic ready;
  logic obstructed;

  modport source (output valid, obstructed, input ready);
  modport sink   (input valid, obstructed, output ready);
endinterface

### sv/sphere_box_overlap_test_top.sv
// Sphere against oriented box overlap test, top level.
// Depends on sbot_pkg and the channel interfaces in sbot_if.sv.
// Seven-stage pipeline, configuration registers held locally.
`timescale 1ns / 1ps

// One query transaction in, one result transaction out, in order. The block
// is a seven-stage pipeline and takes a new query every cycle unless the
// result side stalls. The multiplier stages (nine 16x25 rotation products,
// then four 24x24 squares) set the depth. A stall on the result side freezes
// the whole pipeline, so query.ready is low only while a result waits and
// result.ready is low. The box (centre, half extents, rotation rows, enable)
// is written through cfg_wen/cfg_addr/cfg_data and must only change while no
// transaction is in flight; it is read live by the stages that use it.
// Local coordinates are the rotation rows applied to (sphere - centre),
// rounded to nearest with ties upward; a touch counts as obstructed.
module sphere_box_overlap_test_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [sbot_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
  input  logic [sbot_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  sbot_query_if.sink                             query,
  sbot_result_if.source                          result
);

  // ---------------- configuration registers ----------------
  sbot_pkg::coord_t                            box_center [3];
  logic [sbot_pkg::HALF_EXT_WIDTH-1:0]         half_extents;
  logic [sbot_pkg::ROT_ROW_WIDTH-1:0]          rot_row [3];
  logic                                        collision_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_center[0]     <= '0;
      box_center[1]     <= '0;
      box_center[2]     <= '0;
      half_extents      <= '0;
      rot_row[0]        <= sbot_pkg::ROT_ROW_0_RESET;
      rot_row[1]        <= sbot_pkg::ROT_ROW_1_RESET;
      rot_row[2]        <= sbot_pkg::ROT_ROW_2_RESET;
      collision_enabled <= 1'b1;
    end else if (cfg_wen) begin
      case (sbot_pkg::cfg_addr_t'(cfg_addr))
        sbot_pkg::CFG_BOX_CENTER_X: box_center[0] <= cfg_data[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_BOX_CENTER_Y: box_center[1] <= cfg_data[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_BOX_CENTER_Z: box_center[2] <= cfg_data[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_HALF_EXTENTS: half_extents <= cfg_data[sbot_pkg::HALF_EXT_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_0:    rot_row[0] <= cfg_data[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_1:    rot_row[1] <= cfg_data[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_2:    rot_row[2] <= cfg_data[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_COLLISION_EN: collision_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Matrix entries and half extents unpacked from the register fields
  sbot_pkg::rot_t rot_e [3][3];
  sbot_pkg::ext_t half_ext [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      half_ext[r] = half_extents[r*sbot_pkg::EXT_BITS +: sbot_pkg::EXT_BITS];
      for (int c = 0; c < 3; c++) begin
        rot_e[r][c] = rot_row[r][c*sbot_pkg::ROT_BITS +: sbot_pkg::ROT_BITS];
      end
    end
  end

  // ---------------- pipeline control ----------------
  // Single global advance: everything moves unless the output register holds
  // a result that is not being taken.
  logic v1, v2, v3, v4, v5, v6, v7;
  logic advance;

  assign advance      = !v7 || result.ready;
  assign query.ready  = advance;
  assign result.valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (advance) begin
      v1 <= query.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // ---------------- payload stages ----------------
  // S1: offset from box centre
  sbot_pkg::diff_t   d1 [3];
  sbot_pkg::radius_t r1, r2, r3, r4, r5;
  // S2: rotation products
  sbot_pkg::prod_t   p2 [3][3];
  // S3: rounded local coordinates
  sbot_pkg::local_t  loc3 [3];
  // S4: excess beyond the upper and lower face of each slab
  sbot_pkg::dist_t   hi4 [3];
  sbot_pkg::dist_t   lo4 [3];
  // S5: per-axis distance, fits the radius width unless fail5 is set
  sbot_pkg::radius_t dist5 [3];
  logic              fail5;
  // S6: squares
  sbot_pkg::sq_t     sq6 [3];
  sbot_pkg::sq_t     rsq6;
  logic              fail6;
  // S7: output register
  logic              obstructed;

  sbot_pkg::coord_t  sphere [3];
  sbot_pkg::sum_t    row_sum [3];
  sbot_pkg::sum_t    row_rnd [3];
  sbot_pkg::dist_t   hs [3];
  sbot_pkg::dist_t   dist_sel [3];
  logic [2:0]        axis_fail;
  sbot_pkg::total_t  total;

  assign sphere[0] = query.sphere_x;
  assign sphere[1] = query.sphere_y;
  assign sphere[2] = query.sphere_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = sbot_pkg::sum_t'(p2[r][0]) + sbot_pkg::sum_t'(p2[r][1])
                 + sbot_pkg::sum_t'(p2[r][2]);
      row_rnd[r] = row_sum[r] + sbot_pkg::ROUND_HALF;
      hs[r]      = sbot_pkg::dist_t'(half_ext[r]);   // zero-extended
      // Outside above, outside below, or inside the slab
      if (hi4[r] > 0) begin
        dist_sel[r] = hi4[r];
      end else if (lo4[r] > 0) begin
        dist_sel[r] = lo4[r];
      end else begin
        dist_sel[r] = '0;
      end
      axis_fail[r] = dist_sel[r] > sbot_pkg::dist_t'(r4);
    end
    total = sbot_pkg::total_t'(sq6[0]) + sbot_pkg::total_t'(sq6[1])
          + sbot_pkg::total_t'(sq6[2]);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // S1
      for (int c = 0; c < 3; c++) begin
        d1[c] <= sbot_pkg::diff_t'(sphere[c]) - sbot_pkg::diff_t'(box_center[c]);
      end
      r1 <= query.sphere_radius;
      // S2
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p2[r][c] <= rot_e[r][c] * d1[c];
        end
      end
      r2 <= r1;
      // S3: arithmetic shift after rounding bias is a floor, as required
      for (int r = 0; r < 3; r++) begin
        loc3[r] <= row_rnd[r][sbot_pkg::SUM_W-1:sbot_pkg::ROT_FRAC_BITS];
      end
      r3 <= r2;
      // S4
      for (int r = 0; r < 3; r++) begin
        hi4[r] <= sbot_pkg::dist_t'(loc3[r]) - hs[r];
        lo4[r] <= -hs[r] - sbot_pkg::dist_t'(loc3[r]);
      end
      r4 <= r3;
      // S5: an axis already beyond the radius decides the answer
      for (int r = 0; r < 3; r++) begin
        dist5[r] <= dist_sel[r][sbot_pkg::COORD_WIDTH-1:0];
      end
      fail5 <= |axis_fail;
      r5    <= r4;
      // S6
      for (int r = 0; r < 3; r++) begin
        sq6[r] <= sbot_pkg::sq_t'(dist5[r]) * sbot_pkg::sq_t'(dist5[r]);
      end
      rsq6  <= sbot_pkg::sq_t'(r5) * sbot_pkg::sq_t'(r5);
      fail6 <= fail5;
      // S7
      obstructed <= collision_enabled && !fail6 && (total <= sbot_pkg::total_t'(rsq6));
    end
  end

  assign result.obstructed = obstructed;

endmodule

### sv/sbot_checker.sv
// Port-level assertions for the sphere/oriented-box overlap test.
// Bound to sphere_box_overlap_test_top; sees only its ports.
`timescale 1ns / 1ps

module sbot_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_obstructed
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_obstructed))
    else $error("result changed while stalled");

  // Back-pressure only when the output register is blocked
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("query ready does not follow output stall");

  // With the result side ready throughout, an accepted query comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
     ##1 out_ready ##1 out_ready) |=> out_valid)
    else $error("result missing after pipeline latency");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind sphere_box_overlap_test_top sbot_checker u_sbot_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (query.valid),
  .in_ready       (query.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_obstructed (result.obstructed)
);

### sim/tb.sv
// Self-checking testbench for the sphere against oriented box overlap test.
// Depends on sbot_pkg, the channel interfaces in sbot_if.sv and the top level.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    sbot_pkg::coord_t  x;
    sbot_pkg::coord_t  y;
    sbot_pkg::coord_t  z;
    sbot_pkg::radius_t r;
  } sphere_t;

  typedef struct packed {
    sbot_pkg::coord_t                          cx;
    sbot_pkg::coord_t                          cy;
    sbot_pkg::coord_t                          cz;
    logic [sbot_pkg::HALF_EXT_WIDTH-1:0]       ext;
    logic [2:0][sbot_pkg::ROT_ROW_WIDTH-1:0]   rows;
    logic                                      en;
  } box_t;

  // Cos/sin pairs in Q1.14 for plane rotations
  localparam int COS_Q14 [5] = '{16384, 15137, 14189, 11585, 8192};
  localparam int SIN_Q14 [5] = '{0, 6270, 8192, 11585, 14189};

  // Box model plus the queue of obstructed flags still owed by the block
  class overlap_scoreboard;
    sbot_pkg::coord_t                      centre [3];
    logic [sbot_pkg::HALF_EXT_WIDTH-1:0]   extents;
    logic [sbot_pkg::ROT_ROW_WIDTH-1:0]    rows [3];
    bit                                    enabled;
    bit                                    expected_obstructed [$];
    int unsigned                           mismatches;
    int unsigned                           checked;
    int unsigned                           hits;

    function new();
      centre     = '{default: '0};
      extents    = '0;
      rows[0]    = sbot_pkg::ROT_ROW_0_RESET;
      rows[1]    = sbot_pkg::ROT_ROW_1_RESET;
      rows[2]    = sbot_pkg::ROT_ROW_2_RESET;
      enabled    = 1'b1;
      mismatches = 0;
      checked    = 0;
      hits       = 0;
    endfunction

    function void set_register(sbot_pkg::cfg_addr_t a,
                               logic [sbot_pkg::CFG_DATA_WIDTH-1:0] d);
      case (a)
        sbot_pkg::CFG_BOX_CENTER_X: centre[0] = d[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_BOX_CENTER_Y: centre[1] = d[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_BOX_CENTER_Z: centre[2] = d[sbot_pkg::COORD_WIDTH-1:0];
        sbot_pkg::CFG_HALF_EXTENTS: extents   = d[sbot_pkg::HALF_EXT_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_0:    rows[0]   = d[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_1:    rows[1]   = d[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_ROT_ROW_2:    rows[2]   = d[sbot_pkg::ROT_ROW_WIDTH-1:0];
        sbot_pkg::CFG_COLLISION_EN: enabled   = d[0];
        default: ;
      endcase
    endfunction

    function bit predict_obstructed(sphere_t s);
      longint diff [3];
      longint acc, loc, h, sep, rad, total;
      sbot_pkg::rot_t e;
      diff[0] = longint'($signed(s.x)) - longint'(centre[0]);
      diff[1] = longint'($signed(s.y)) - longint'(centre[1]);
      diff[2] = longint'($signed(s.z)) - longint'(centre[2]);
      rad     = longint'(s.r);
      total   = 0;
      if (!enabled)
        return 1'b0;
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) begin
          e   = rows[r][c*sbot_pkg::ROT_BITS +: sbot_pkg::ROT_BITS];
          acc = acc + longint'(e) * diff[c];
        end
        // nearest, ties upward: arithmetic shift floors
        loc = (acc + (longint'(1) << (sbot_pkg::ROT_FRAC_BITS - 1)))
              >>> sbot_pkg::ROT_FRAC_BITS;
        h   = longint'(extents[r*sbot_pkg::EXT_BITS +: sbot_pkg::EXT_BITS]);
        if (loc > h)
          sep = loc - h;
        else if (loc < -h)
          sep = -h - loc;
        else
          sep = 0;
        if (sep > rad)
          return 1'b0;
        total = total + sep * sep;
      end
      return total <= rad * rad;
    endfunction

    function void note_query(sphere_t s);
      expected_obstructed.push_back(predict_obstructed(s));
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_obstructed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %b arrived with nothing outstanding", $realtime, got);
      end else begin
        want = expected_obstructed.pop_front();
        checked++;
        if (want)
          hits++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: obstructed mismatch, expected %b got %b", $realtime, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_obstructed.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_wen;
  logic [sbot_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [sbot_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

  sbot_query_if  query_ch ();
  sbot_result_if result_ch ();

  sphere_box_overlap_test_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .query    (query_ch),
    .result   (result_ch)
  );

  overlap_scoreboard sb = new();

  // Idle percentages per side, changed between phases
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned box_count   = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side back-pressure: one fresh draw per edge
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: queries are predicted as they are accepted, results checked
  // in order. Both sample pre-edge values, so no race with the drivers.
  always @(posedge clk) begin
    if (!rst) begin
      if (query_ch.valid === 1'b1 && query_ch.ready === 1'b1)
        sb.note_query(sphere_t'{query_ch.sphere_x, query_ch.sphere_y,
                                query_ch.sphere_z, query_ch.sphere_radius});
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        sb.check_result(result_ch.obstructed);
    end
  end

  // Safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint spread(longint r);
    return longint'($urandom_range(int'(2 * r))) - r;
  endfunction

  function automatic sbot_pkg::coord_t pick_coord(sbot_pkg::coord_t c);
    case ($urandom_range(4))
      0:       return {1'b1, {(sbot_pkg::COORD_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(sbot_pkg::COORD_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return c;
    endcase
  endfunction

  // Random box; k sets the size of the extents in bits
  function automatic box_t random_box(int k);
    box_t           b;
    sbot_pkg::rot_t m [3][3];
    int             p [3];
    int             t, i, j, a, s;
    b.cx = ($urandom_range(3) == 0) ? sbot_pkg::coord_t'($urandom)
                                    : sbot_pkg::coord_t'(spread(1 << 22));
    b.cy = ($urandom_range(3) == 0) ? sbot_pkg::coord_t'($urandom)
                                    : sbot_pkg::coord_t'(spread(1 << 22));
    b.cz = ($urandom_range(3) == 0) ? sbot_pkg::coord_t'($urandom)
                                    : sbot_pkg::coord_t'(spread(1 << 22));
    for (int r = 0; r < 3; r++) begin
      case ($urandom_range(7))
        0:       b.ext[r*sbot_pkg::EXT_BITS +: sbot_pkg::EXT_BITS] = '1;
        1:       b.ext[r*sbot_pkg::EXT_BITS +: sbot_pkg::EXT_BITS] = '0;
        default: b.ext[r*sbot_pkg::EXT_BITS +: sbot_pkg::EXT_BITS] =
                   sbot_pkg::ext_t'($urandom_range(1 << k));
      endcase
    end
    m = '{default: sbot_pkg::ROT_ZERO};
    case ($urandom_range(3))
      0: begin
        // signed axis permutation
        p = '{0, 1, 2};
        for (int n = 2; n > 0; n--) begin
          j    = $urandom_range(n);
          t    = p[n];
          p[n] = p[j];
          p[j] = t;
        end
        for (int r = 0; r < 3; r++)
          m[r][p[r]] = $urandom_range(1) ? sbot_pkg::ROT_ONE
                                         : sbot_pkg::rot_t'(-int'(sbot_pkg::ROT_ONE));
      end
      1: begin
        // rotation in one coordinate plane
        a = $urandom_range(4);
        i = $urandom_range(2);
        j = (i + 1 + $urandom_range(1)) % 3;
        s = $urandom_range(1) ? 1 : -1;
        m[3 - i - j][3 - i - j] = sbot_pkg::ROT_ONE;
        m[i][i] = sbot_pkg::rot_t'(COS_Q14[a]);
        m[j][j] = sbot_pkg::rot_t'(COS_Q14[a]);
        m[i][j] = sbot_pkg::rot_t'(-s * SIN_Q14[a]);
        m[j][i] = sbot_pkg::rot_t'(s * SIN_Q14[a]);
      end
      2: begin
        // anything at all
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            m[r][c] = sbot_pkg::rot_t'($urandom);
      end
      default: begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            m[r][c] = sbot_pkg::rot_t'(spread(1 << sbot_pkg::ROT_FRAC_BITS));
      end
    endcase
    for (int r = 0; r < 3; r++)
      b.rows[r] = {m[r][2], m[r][1], m[r][0]};
    b.en = ($urandom_range(9) != 0);
    return b;
  endfunction

  // Mostly spheres around the box at its own scale, some noise and extremes
  function automatic sphere_t random_sphere(box_t b, int k);
    sphere_t s;
    int      mode;
    longint  reach;
    mode = $urandom_range(99);
    if (mode < 70) begin
      s.r   = sbot_pkg::radius_t'($urandom_range(1 << k));
      reach = (longint'(1) << (k + 1)) + longint'(s.r);
      s.x   = sbot_pkg::coord_t'(longint'(b.cx) + spread(reach));
      s.y   = sbot_pkg::coord_t'(longint'(b.cy) + spread(reach));
      s.z   = sbot_pkg::coord_t'(longint'(b.cz) + spread(reach));
    end else if (mode < 85) begin
      s = sphere_t'({$urandom, $urandom, $urandom});
    end else begin
      s.x = pick_coord(b.cx);
      s.y = pick_coord(b.cy);
      s.z = pick_coord(b.cz);
      case ($urandom_range(3))
        0:       s.r = '0;
        1:       s.r = '1;
        2:       s.r = sbot_pkg::radius_t'(1);
        default: s.r = sbot_pkg::radius_t'($urandom);
      endcase
    end
    return s;
  endfunction

  // Hold valid until the query transaction is taken, with random gaps first
  task automatic send_query(sphere_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid         <= 1'b1;
    query_ch.sphere_x      <= s.x;
    query_ch.sphere_y      <= s.y;
    query_ch.sphere_z      <= s.z;
    query_ch.sphere_radius <= s.r;
    do
      @(posedge clk);
    while (query_ch.ready !== 1'b1);
  endtask

  // Stop sending and let every outstanding result come back; wait on the clock
  // first so the monitor has logged the last accepted query
  task automatic drain();
    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // All eight registers back to back; junk above each narrower register's width
  task automatic write_box(box_t b);
    sbot_pkg::cfg_addr_t                 idx;
    logic [sbot_pkg::CFG_DATA_WIDTH-1:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = sbot_pkg::cfg_addr_t'(i);
      val = sbot_pkg::CFG_DATA_WIDTH'({$urandom, $urandom});
      case (idx)
        sbot_pkg::CFG_BOX_CENTER_X: val[sbot_pkg::COORD_WIDTH-1:0]   = b.cx;
        sbot_pkg::CFG_BOX_CENTER_Y: val[sbot_pkg::COORD_WIDTH-1:0]   = b.cy;
        sbot_pkg::CFG_BOX_CENTER_Z: val[sbot_pkg::COORD_WIDTH-1:0]   = b.cz;
        sbot_pkg::CFG_HALF_EXTENTS: val                              = b.ext;
        sbot_pkg::CFG_ROT_ROW_0:    val[sbot_pkg::ROT_ROW_WIDTH-1:0] = b.rows[0];
        sbot_pkg::CFG_ROT_ROW_1:    val[sbot_pkg::ROT_ROW_WIDTH-1:0] = b.rows[1];
        sbot_pkg::CFG_ROT_ROW_2:    val[sbot_pkg::ROT_ROW_WIDTH-1:0] = b.rows[2];
        default:                    val[0]                           = b.en;
      endcase
      cfg_wen  <= 1'b1;
      cfg_addr <= idx;
      cfg_data <= val;
      @(posedge clk);
      sb.set_register(idx, val);
    end
    cfg_wen <= 1'b0;
    box_count++;
  endtask

  initial begin
    box_t             b;
    sbot_pkg::coord_t cmin, cmax;
    int               k;
    cmin = {1'b1, {(sbot_pkg::COORD_WIDTH-1){1'b0}}};
    cmax = {1'b0, {(sbot_pkg::COORD_WIDTH-1){1'b1}}};

    rst                    <= 1'b1;
    cfg_wen                <= 1'b0;
    cfg_addr               <= '0;
    cfg_data               <= '0;
    query_ch.valid         <= 1'b0;
    query_ch.sphere_x      <= '0;
    query_ch.sphere_y      <= '0;
    query_ch.sphere_z      <= '0;
    query_ch.sphere_radius <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the first idle mix
    tx_idle_pct = 9;
    rx_idle_pct = 54;

    // Reset box: identity, point extents at the origin, enabled
    send_query(sphere_t'{sbot_pkg::coord_t'(0), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{sbot_pkg::coord_t'(1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(0)});
    // touching
    send_query(sphere_t'{sbot_pkg::coord_t'(1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(1)});
    send_query(sphere_t'{cmax, cmax, cmax, sbot_pkg::radius_t'('1)});
    send_query(sphere_t'{cmin, cmin, cmin, sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{cmin, cmax, cmin, sbot_pkg::radius_t'('1)});
    drain();

    // Half-weight entries: rounding ties go up on both signs
    b.cx = '0; b.cy = '0; b.cz = '0; b.ext = '0; b.en = 1'b1;
    b.rows[0] = {sbot_pkg::ROT_ZERO, sbot_pkg::ROT_ZERO, sbot_pkg::rot_t'(16'sh2000)};
    b.rows[1] = {sbot_pkg::ROT_ZERO, sbot_pkg::ROT_ZERO, sbot_pkg::rot_t'(-16'sh2000)};
    b.rows[2] = '0;
    write_box(b);
    send_query(sphere_t'{sbot_pkg::coord_t'(1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{sbot_pkg::coord_t'(1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(1)});
    send_query(sphere_t'{sbot_pkg::coord_t'(-1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{sbot_pkg::coord_t'(-1), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(1)});
    drain();

    // Corner of the range: extreme centre, full extents, non-rotation matrix
    b.cx = cmax; b.cy = cmin; b.cz = cmax; b.ext = '1; b.en = 1'b1;
    b.rows[0] = {16'sh8000, 16'sh7fff, 16'sh8000};
    b.rows[1] = {16'sh7fff, 16'sh7fff, 16'sh7fff};
    b.rows[2] = {16'sh8000, 16'sh8000, 16'sh8000};
    write_box(b);
    send_query(sphere_t'{cmin, cmax, cmin, sbot_pkg::radius_t'('1)});
    send_query(sphere_t'{cmax, cmin, cmax, sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{cmin, cmin, cmin, sbot_pkg::radius_t'(0)});
    send_query(sphere_t'{cmax, cmax, cmax, sbot_pkg::radius_t'('1)});
    send_query(sphere_t'{sbot_pkg::coord_t'(0), sbot_pkg::coord_t'(0),
                         sbot_pkg::coord_t'(0), sbot_pkg::radius_t'(0)});
    drain();

    // Same box with collision off: never obstructed, even dead centre
    b.en = 1'b0;
    write_box(b);
    send_query(sphere_t'{cmax, cmin, cmax, sbot_pkg::radius_t'('1)});
    send_query(sphere_t'{cmin, cmax, cmin, sbot_pkg::radius_t'(0)});
    drain();

    // Random part: three idle mixes, five boxes each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 9;  rx_idle_pct = 54; end
        1: begin tx_idle_pct = 54; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int nb = 0; nb < 5; nb++) begin
        k = (nb == 0) ? $urandom_range(2, 6) : $urandom_range(2, 20);
        b = random_box(k);
        drain();
        write_box(b);
        for (int n = 0; n < 100; n++) begin
          // one mid-stream hold-off until the pipe is empty
          if (phase == 1 && nb == 2 && n == 50)
            drain();
          send_query(random_sphere(b, k));
        end
      end
    end

    drain();
    $display("%0d sphere queries checked against %0d box settings under three idle mixes",
             sb.checked, box_count);
    $display("%0d obstructed, %0d clear, %0d mismatches",
             sb.hits, sb.checked - sb.hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
sv/sbot_pkg.sv
sv/sbot_if.sv
sv/sphere_box_overlap_test_top.sv
sv/sbot_checker.sv
sim/tb.sv
